/* rtl/ilws_pkg.sv */
// Shared types and constants for the indexed list with shift.
// Used by ilws_cell and indexed_list_with_shift; no dependencies.
package ilws_pkg;

    localparam int CAPACITY = 32;
    // Width of the entry count, able to hold CAPACITY itself
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Width of a cell position
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IN_IDX_W = 6;
    localparam int END_W    = 5;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 6;
    localparam int STAT_W   = 2;
    // Common width for position compares
    localparam int CMP_W    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_DROP   = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_RESIZE = 3'd5,
        CMD_CLEAR  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CO_HOLD,
        CO_INSERT,
        CO_SHIFT,
        CO_ZERO
    } t_cell_op;

    // Broadcast to every cell; each cell decides its own move from its position
    typedef struct packed {
        t_cell_op            op;
        logic [CMP_W-1:0]    lo;
        logic [CMP_W-1:0]    hi;
        logic [WORD_W-1:0]   value;
    } t_cell_ctl;

    typedef enum logic {
        FSM_IDLE,
        FSM_ERASE
    } t_fsm;

endpackage

/* rtl/ilws_cell.sv */
// One list entry of the cell chain: loads, takes a neighbor's word, or zeroes.
// Depends on ilws_pkg for the control struct and widths.
module ilws_cell
    import ilws_pkg::*;
(
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [CMP_W-1:0]    i_pos,
    input  logic [WORD_W-1:0]   i_left,
    input  logic [WORD_W-1:0]   i_right,
    output logic [WORD_W-1:0]   o_word
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            CO_INSERT: begin
                if (i_pos == i_ctl.lo) begin
                    n_word = i_ctl.value;
                end else if (i_pos > i_ctl.lo && i_pos <= i_ctl.hi) begin
                    n_word = i_left;
                end
            end
            CO_SHIFT: begin
                // move down one place per cycle from the erase start on
                if (i_pos >= i_ctl.lo) begin
                    n_word = i_right;
                end
            end
            CO_ZERO: begin
                if (i_pos >= i_ctl.lo && i_pos < i_ctl.hi) begin
                    n_word = '0;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

/* rtl/indexed_list_with_shift.sv */
// Bounded ordered list of 32-bit words held in a chain of cells, one per entry.
// Depends on ilws_pkg and ilws_cell.
//
// Each command item gives exactly one result item. Append, drop, insert, read,
// resize, clear and every rejected command finish without entering the erase
// shift state: insert moves all later cells up one place at once. An erase of
// more than one position stays in that state, because the chain moves words down
// one cell per cycle; no command is accepted during the shift. A new command is
// taken only when the output register is empty or its result is being taken in
// the same cycle, and never while reset is held. Stored words beyond the length
// have no reset value; nothing can read them, so no clearing pass follows reset.
module indexed_list_with_shift
    import ilws_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // value[31:0], index[37:32], end_index[42:38], zero fill[47:43]
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // read_word[31:0], length[37:32], status[39:38]
    output logic [OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);

    t_fsm               r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [CMP_W-1:0]   r_lo, n_lo;
    logic               r_out_valid, n_out_valid;
    logic [WORD_W-1:0]  r_out_word, n_out_word;
    logic [LEN_W-1:0]   r_out_len, n_out_len;
    t_status            r_out_status, n_out_status;

    t_cell_ctl          w_ctl;
    logic [WORD_W-1:0]  w_word [CAPACITY];
    logic               w_accept;
    logic [WORD_W-1:0]  w_value;
    logic [CMP_W-1:0]   w_idx;
    logic [CMP_W-1:0]   w_end;
    logic [CMP_W-1:0]   w_cnt;
    logic [CMP_W-1:0]   w_gap;
    logic [CMP_W-1:0]   w_new_cnt;
    logic               w_erase_start;
    t_cmd               w_cmd;

    assign w_value = s_axis_tdata[WORD_W-1:0];
    assign w_idx   = CMP_W'(s_axis_tdata[WORD_W +: IN_IDX_W]);
    assign w_end   = CMP_W'(s_axis_tdata[WORD_W + IN_IDX_W +: END_W]);
    assign w_cmd   = t_cmd'(s_axis_tuser);
    assign w_cnt   = CMP_W'(r_cnt);
    assign w_gap   = w_end - w_idx + CMP_W'(1);

    assign s_axis_tready = i_rst_n && (r_state == FSM_IDLE)
                           && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [WORD_W-1:0] w_left;
            logic [WORD_W-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_word[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_word[gi+1];
            end
            ilws_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_pos   (CMP_W'(gi)),
                .i_left  (w_left),
                .i_right (w_right),
                .o_word  (w_word[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_rem         = r_rem;
        n_lo          = r_lo;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_word    = r_out_word;
        n_out_len     = r_out_len;
        n_out_status  = r_out_status;
        w_ctl.op      = CO_HOLD;
        w_ctl.lo      = w_idx;
        w_ctl.hi      = w_cnt;
        w_ctl.value   = w_value;
        w_new_cnt     = w_cnt;
        w_erase_start = 1'b0;

        case (r_state)
            FSM_IDLE: begin
                if (w_accept) begin
                    n_out_word   = '0;
                    n_out_status = ST_OK;
                    case (w_cmd)
                        CMD_APPEND: begin
                            if (w_cnt >= CAP_X) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_ctl.op  = CO_INSERT;
                                w_ctl.lo  = w_cnt;
                                w_new_cnt = w_cnt + CMP_W'(1);
                            end
                        end
                        CMD_DROP: begin
                            if (w_cnt == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                w_new_cnt = w_cnt - CMP_W'(1);
                            end
                        end
                        CMD_INSERT: begin
                            if (w_idx > w_cnt) begin
                                n_out_status = ST_BAD;
                            end else if (w_cnt >= CAP_X) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_ctl.op  = CO_INSERT;
                                w_new_cnt = w_cnt + CMP_W'(1);
                            end
                        end
                        CMD_ERASE: begin
                            if (w_cnt == '0) begin
                                n_out_status = ST_EMPTY;
                            end else if (w_idx > w_end || w_end >= w_cnt) begin
                                n_out_status = ST_BAD;
                            end else begin
                                // first place of the shift happens now
                                w_ctl.op  = CO_SHIFT;
                                w_new_cnt = w_cnt - w_gap;
                                if (w_gap != CMP_W'(1)) begin
                                    w_erase_start = 1'b1;
                                    n_state       = FSM_ERASE;
                                    n_rem         = CNT_W'(w_gap - CMP_W'(1));
                                    n_lo          = w_idx;
                                end
                            end
                        end
                        CMD_READ: begin
                            if (w_idx >= w_cnt) begin
                                n_out_status = ST_BAD;
                            end else begin
                                n_out_word = w_word[w_idx[IDX_W-1:0]];
                            end
                        end
                        CMD_RESIZE: begin
                            if (w_idx > CAP_X) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_ctl.op  = CO_ZERO;
                                w_ctl.lo  = w_cnt;
                                w_ctl.hi  = w_idx;
                                w_new_cnt = w_idx;
                            end
                        end
                        CMD_CLEAR: begin
                            w_new_cnt = '0;
                        end
                        default: begin
                            n_out_status = ST_BAD;
                        end
                    endcase
                    n_cnt       = CNT_W'(w_new_cnt);
                    n_out_len   = w_new_cnt[LEN_W-1:0];
                    n_out_valid = !w_erase_start;
                end
            end
            FSM_ERASE: begin
                w_ctl.op = CO_SHIFT;
                w_ctl.lo = r_lo;
                n_rem    = r_rem - CNT_W'(1);
                if (r_rem == CNT_W'(1)) begin
                    n_state      = FSM_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_word   = '0;
                    n_out_status = ST_OK;
                    n_out_len    = w_cnt[LEN_W-1:0];
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_IDLE;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_out_word   <= n_out_word;
        r_out_len    <= n_out_len;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_status, r_out_len, r_out_word};

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_cnt) <= CAP_X)
        else $error("entry count above capacity");

    a_erase_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FSM_ERASE) |-> (!s_axis_tready && r_rem != '0 && !r_out_valid))
        else $error("erase shift state inconsistent");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_erase_start) |=> r_out_valid)
        else $error("accepted item gave no result");

    a_erase_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FSM_ERASE && r_rem == CNT_W'(1)) |=>
            (r_state == FSM_IDLE && r_out_valid))
        else $error("erase did not finish with a result");
`endif

endmodule
